// ===== rtl/core/char_stream_tokenizer_defines.svh =====
// Assertion helpers shared by the tokenizer RTL.
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

// Check that an antecedent always brings a consequent in the same cycle.
`define CST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition never occurs.
`define CST_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/cst_pkg.sv =====
`timescale 1ns / 1ps
package cst_pkg;

	localparam int LENGTH_WIDTH = 16;
	localparam int VALUE_W      = 63;
	localparam int TLEN_W       = 16;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REC_TEXT  = 2'd0,
		REC_TOKEN = 2'd1,
		REC_ERROR = 2'd2,
		REC_END   = 2'd3
	} rec_class_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_NUMBER = 3'd1,
		MODE_IDENT  = 3'd2,
		MODE_STRING = 3'd3,
		MODE_ERROR  = 3'd4
	} scan_mode_t;

	typedef enum logic [2:0] {
		CC_SPACE  = 3'd0,
		CC_DIGIT  = 3'd1,
		CC_LETTER = 3'd2,
		CC_QUOTE  = 3'd3,
		CC_PUNCT  = 3'd4,
		CC_OTHER  = 3'd5
	} char_class_t;

	localparam logic [4:0] KIND_NUMBER     = 5'd0;
	localparam logic [4:0] KIND_IDENT      = 5'd1;
	localparam logic [4:0] KIND_STRING     = 5'd2;
	localparam logic [4:0] KIND_PUNCT_BASE = 5'd3;

	localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
	localparam logic [1:0] ERR_STRING     = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW   = 2'd2;

	typedef struct packed {
		rec_class_t          cls;
		logic [4:0]          kind;
		logic [VALUE_W-1:0]  value;
		logic [7:0]          tbyte;
		logic [TLEN_W-1:0]   tlen;
		logic [1:0]          err;
	} rec_t;

	typedef struct packed {
		logic two;
		rec_t rec1;
		rec_t rec0;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// 16 punctuation tokens, index 0..15; valid flag in bit 4
	function automatic logic [4:0] punct_lookup(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			8'h2A:   r = 5'h10;
			8'h40:   r = 5'h11;
			8'h5E:   r = 5'h12;
			8'h29:   r = 5'h13;
			8'h5D:   r = 5'h14;
			8'h3A:   r = 5'h15;
			8'h2E:   r = 5'h16;
			8'h3D:   r = 5'h17;
			8'h2D:   r = 5'h18;
			8'h28:   r = 5'h19;
			8'h5B:   r = 5'h1A;
			8'h2B:   r = 5'h1B;
			8'h3B:   r = 5'h1C;
			8'h2F:   r = 5'h1D;
			8'h7B:   r = 5'h1E;
			8'h7D:   r = 5'h1F;
			default: r = 5'h00;
		endcase
		return r;
	endfunction

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cc;
		logic [4:0]  p;
		p = punct_lookup(c);
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			cc = CC_SPACE;
		else if (c >= 8'h30 && c <= 8'h39)
			cc = CC_DIGIT;
		else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
			cc = CC_LETTER;
		else if (c == 8'h22)
			cc = CC_QUOTE;
		else if (p[4])
			cc = CC_PUNCT;
		else
			cc = CC_OTHER;
		return cc;
	endfunction

endpackage

// ===== rtl/core/cst_front.sv =====
`timescale 1ns / 1ps
module cst_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    char_in,
	input  logic          end_in,
	output logic          push,
	output cst_pkg::pkt_t pkt
);

	cst_pkg::scan_mode_t                  mode_q, mode_d;
	logic [cst_pkg::VALUE_W-1:0]          acc_q, acc_d;
	logic [cst_pkg::LENGTH_WIDTH-1:0]     cnt_q, cnt_d, cnt_inc;
	cst_pkg::char_class_t                 ccls;
	logic [4:0]                           pidx;
	logic [3:0]                           digit;
	logic [cst_pkg::VALUE_W+3:0]          prod;
	logic                                 ovf;
	logic                                 has;
	cst_pkg::rec_t                        st_rec, num_done, id_done, end_rec;
	logic                                 st_has;

	function automatic cst_pkg::rec_t mk(
		input cst_pkg::rec_class_t         cls,
		input logic [4:0]                  kind,
		input logic [cst_pkg::VALUE_W-1:0] value,
		input logic [7:0]                  tbyte,
		input logic [cst_pkg::TLEN_W-1:0]  tlen,
		input logic [1:0]                  err
	);
		cst_pkg::rec_t r;
		r.cls   = cls;
		r.kind  = kind;
		r.value = value;
		r.tbyte = tbyte;
		r.tlen  = tlen;
		r.err   = err;
		return r;
	endfunction

	function automatic logic [cst_pkg::TLEN_W-1:0] len_out(
		input logic [cst_pkg::LENGTH_WIDTH-1:0] n
	);
		logic [31:0] w;
		w = 32'(n);
		return (w > 32'h0000_FFFF) ? '1 : w[cst_pkg::TLEN_W-1:0];
	endfunction

	assign ccls    = cst_pkg::classify(char_in);
	assign pidx    = cst_pkg::punct_lookup(char_in);
	assign digit   = char_in[3:0];
	// acc * 10 + digit, as shifts and adds; top bits flag overflow
	assign prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (cst_pkg::VALUE_W + 4)'(digit);
	assign ovf     = |prod[cst_pkg::VALUE_W+3:cst_pkg::VALUE_W];
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	// next state
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		if (end_in) begin
			mode_d = cst_pkg::MODE_IDLE;
			acc_d  = '0;
			cnt_d  = '0;
		end else begin
			case (mode_q)
				cst_pkg::MODE_NUMBER: begin
					if (ccls == cst_pkg::CC_DIGIT) begin
						if (ovf)
							mode_d = cst_pkg::MODE_ERROR;
						else
							acc_d = prod[cst_pkg::VALUE_W-1:0];
					end
				end
				cst_pkg::MODE_IDENT: begin
					if (ccls == cst_pkg::CC_LETTER)
						cnt_d = cnt_inc;
				end
				cst_pkg::MODE_STRING: begin
					if (ccls == cst_pkg::CC_LETTER) begin
						cnt_d = cnt_inc;
					end else if (ccls == cst_pkg::CC_QUOTE) begin
						mode_d = cst_pkg::MODE_IDLE;
						cnt_d  = '0;
					end else begin
						mode_d = cst_pkg::MODE_ERROR;
						cnt_d  = '0;
					end
				end
				cst_pkg::MODE_IDLE: ;
				default: mode_d = cst_pkg::MODE_ERROR;
			endcase
			// a token ended or none pending: start the next one
			if (mode_q == cst_pkg::MODE_IDLE
				|| (mode_q == cst_pkg::MODE_NUMBER && ccls != cst_pkg::CC_DIGIT)
				|| (mode_q == cst_pkg::MODE_IDENT && ccls != cst_pkg::CC_LETTER)) begin
				acc_d = (ccls == cst_pkg::CC_DIGIT)
					? cst_pkg::VALUE_W'(digit) : '0;
				cnt_d = (ccls == cst_pkg::CC_LETTER)
					? cst_pkg::LENGTH_WIDTH'(1) : '0;
				case (ccls)
					cst_pkg::CC_DIGIT:  mode_d = cst_pkg::MODE_NUMBER;
					cst_pkg::CC_LETTER: mode_d = cst_pkg::MODE_IDENT;
					cst_pkg::CC_QUOTE:  mode_d = cst_pkg::MODE_STRING;
					cst_pkg::CC_OTHER:  mode_d = cst_pkg::MODE_ERROR;
					default:            mode_d = cst_pkg::MODE_IDLE;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		num_done = mk(cst_pkg::REC_TOKEN, cst_pkg::KIND_NUMBER, acc_q, '0, '0, '0);
		id_done  = mk(cst_pkg::REC_TOKEN, cst_pkg::KIND_IDENT, '0, '0, len_out(cnt_q), '0);
		end_rec  = mk(cst_pkg::REC_END, '0, '0, '0, '0, '0);
		st_has   = 1'b1;
		case (ccls)
			cst_pkg::CC_LETTER:
				st_rec = mk(cst_pkg::REC_TEXT, cst_pkg::KIND_IDENT, '0, char_in, '0, '0);
			cst_pkg::CC_PUNCT:
				st_rec = mk(cst_pkg::REC_TOKEN, cst_pkg::KIND_PUNCT_BASE + {1'b0, pidx[3:0]},
					'0, '0, '0, '0);
			cst_pkg::CC_OTHER:
				st_rec = mk(cst_pkg::REC_ERROR, '0, '0, '0, '0, cst_pkg::ERR_UNEXPECTED);
			default: begin
				st_rec = '0;
				st_has = 1'b0;
			end
		endcase

		pkt.rec0 = '0;
		pkt.rec1 = '0;
		pkt.two  = 1'b0;
		has      = 1'b0;
		if (end_in) begin
			has = 1'b1;
			case (mode_q)
				cst_pkg::MODE_NUMBER: begin
					pkt.rec0 = num_done;
					pkt.rec1 = end_rec;
					pkt.two  = 1'b1;
				end
				cst_pkg::MODE_IDENT: begin
					pkt.rec0 = id_done;
					pkt.rec1 = end_rec;
					pkt.two  = 1'b1;
				end
				cst_pkg::MODE_STRING: begin
					pkt.rec0 = mk(cst_pkg::REC_ERROR, '0, '0, '0, '0, cst_pkg::ERR_STRING);
					pkt.rec1 = end_rec;
					pkt.two  = 1'b1;
				end
				default: pkt.rec0 = end_rec;
			endcase
		end else begin
			case (mode_q)
				cst_pkg::MODE_NUMBER: begin
					if (ccls == cst_pkg::CC_DIGIT) begin
						has      = ovf;
						pkt.rec0 = mk(cst_pkg::REC_ERROR, '0, '0, '0, '0,
							cst_pkg::ERR_OVERFLOW);
					end else begin
						has      = 1'b1;
						pkt.rec0 = num_done;
						pkt.rec1 = st_rec;
						pkt.two  = st_has;
					end
				end
				cst_pkg::MODE_IDENT: begin
					has = 1'b1;
					if (ccls == cst_pkg::CC_LETTER) begin
						pkt.rec0 = st_rec;
					end else begin
						pkt.rec0 = id_done;
						pkt.rec1 = st_rec;
						pkt.two  = st_has;
					end
				end
				cst_pkg::MODE_STRING: begin
					has = 1'b1;
					if (ccls == cst_pkg::CC_LETTER)
						pkt.rec0 = mk(cst_pkg::REC_TEXT, cst_pkg::KIND_STRING, '0,
							char_in, '0, '0);
					else if (ccls == cst_pkg::CC_QUOTE)
						pkt.rec0 = mk(cst_pkg::REC_TOKEN, cst_pkg::KIND_STRING, '0, '0,
							len_out(cnt_q), '0);
					else
						pkt.rec0 = mk(cst_pkg::REC_ERROR, '0, '0, '0, '0,
							cst_pkg::ERR_STRING);
				end
				cst_pkg::MODE_IDLE: begin
					has      = st_has;
					pkt.rec0 = st_rec;
				end
				default: has = 1'b0;
			endcase
		end
	end

	assign push = accept && has;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cst_pkg::MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/cst_queue.sv =====
`timescale 1ns / 1ps
module cst_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cst_pkg::pkt_t    wr_pkt,
	input  logic             pop,
	output cst_pkg::pkt_t    head,
	output cst_pkg::q_stat_t stat
);

	cst_pkg::pkt_t                mem_q [cst_pkg::QDEPTH];
	logic [cst_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [cst_pkg::QCNT_W-1:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == cst_pkg::QCNT_W'(cst_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/cst_emit.sv =====
`timescale 1ns / 1ps
module cst_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  cst_pkg::pkt_t    head,
	input  cst_pkg::q_stat_t stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output cst_pkg::rec_t    out_rec,
	output logic             out_last
);

	logic          valid_q;
	logic          sel_q;
	cst_pkg::rec_t rec_q;
	logic          last_q;
	logic          load;

	// advance when the output register is free or being drained
	assign load      = !stat.empty && (!valid_q || out_ready);
	assign pop       = load && (sel_q || !head.two);
	assign out_valid = valid_q;
	assign out_rec   = rec_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (load)
				sel_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q  <= sel_q ? head.rec1 : head.rec0;
			last_q <= pop;
		end
	end

endmodule

// ===== rtl/core/char_stream_tokenizer.sv =====
`timescale 1ns / 1ps
// Longest-match tokenizer for a byte stream.
// Input channel (s_*): one source character per transaction, s_tlast marks
// the end of program (the character is then ignored). Output channel (m_*):
// records of text bytes, completed tokens, errors and an end record; m_tlast
// flags the final record caused by one input character.
// The front stage classifies each character, keeps
// the scan mode, number accumulator (multiply by ten and add) and letter count,
// and writes zero, one or two records as one entry into a four-entry queue.
// The back stage drains one record per cycle into the output register while
// the receiver is ready; records pass through the queue and then that register.
// Throughput is one character per cycle while the receiver is ready and each
// character gives at most one record; a two-record character holds its queue entry until both are sent.
// A stalled receiver fills the queue, and s_tready drops when it is full.
// Reset clears the scan state to idle and empties the queue and output stage.
// After an error all characters are dropped until the end marker.
`include "char_stream_tokenizer_defines.svh"

module char_stream_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_in
	input  logic        s_tlast,  // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	// [62:0] number_value, [70:63] text_byte, [86:71] text_length,
	// [88:87] error_code, [95:89] zero
	output logic [95:0] m_tdata,
	output logic [6:0]  m_tuser,  // [1:0] record_class, [6:2] token_kind
	output logic        m_tlast   // last_of_run
);

	cst_pkg::pkt_t    q_pkt, q_head;
	cst_pkg::q_stat_t q_stat;
	cst_pkg::rec_t    o_rec;
	logic             q_push, q_pop;
	logic             in_acc;

	assign s_tready = !q_stat.full;
	assign in_acc   = s_tvalid && s_tready;

	cst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.char_in (s_tdata),
		.end_in  (s_tlast),
		.push    (q_push),
		.pkt     (q_pkt)
	);

	cst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_pkt (q_pkt),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	cst_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (o_rec),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'b0, o_rec.err, o_rec.tlen, o_rec.tbyte, o_rec.value};
	assign m_tuser = {o_rec.kind, o_rec.cls};

	`CST_ASSERT_IMP(a_end_closes_run, in_acc && s_tlast, q_push && ((q_pkt.two ? q_pkt.rec1.cls : q_pkt.rec0.cls) == cst_pkg::REC_END), "end marker did not queue an end record")
	`CST_ASSERT_NEVER(a_push_when_full, q_push && q_stat.full, "queue written while full")
	`CST_ASSERT_NEVER(a_pop_when_empty, q_pop && q_stat.empty, "queue read while empty")
	`CST_ASSERT_IMP(a_text_kind, m_tvalid && (m_tuser[1:0] == cst_pkg::REC_TEXT), (m_tuser[6:2] == cst_pkg::KIND_IDENT) || (m_tuser[6:2] == cst_pkg::KIND_STRING), "text byte outside identifier or string")

endmodule
